/* hdl/cpq_pkg.sv */
// Shared types, constants and helpers for the command packet queue.
package cpq_pkg;

    localparam int QUEUE_DEPTH      = 8;
    localparam int MAX_PACKET_BYTES = 32;
    localparam int NUM_WORDS        = 4;
    localparam int WORD_W           = 64;
    localparam int LEN_W            = 6;
    localparam int SRC_W            = 16;
    localparam int CTR_W            = 32;
    localparam int FILL_W           = 4;
    localparam int PTR_W            = $clog2(QUEUE_DEPTH);
    localparam int CNT_W            = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        REQ_PUSH     = 2'd0,
        REQ_TAKE     = 2'd1,
        REQ_COMPLETE = 2'd2,
        REQ_CLEAR    = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        OUTC_SENT    = 2'd0,
        OUTC_NOT_YET = 2'd1,
        OUTC_FAILED  = 2'd2
    } outcome_t;

    typedef enum logic [3:0] {
        STAT_PUSHED   = 4'd0,
        STAT_EVICTED  = 4'd1,
        STAT_REJECTED = 4'd2,
        STAT_ISSUED   = 4'd3,
        STAT_NOTHING  = 4'd4,
        STAT_SENT     = 4'd5,
        STAT_HELD     = 4'd6,
        STAT_DROPPED  = 4'd7,
        STAT_CLEARED  = 4'd8,
        STAT_IGNORED  = 4'd9
    } status_t;

    typedef enum logic {
        FSM_IDLE = 1'b0,
        FSM_EXEC = 1'b1
    } fsm_t;

    typedef logic [NUM_WORDS-1:0][WORD_W-1:0] payload_t;

    // One stored packet: queue entry and hold slot share this layout
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [SRC_W-1:0] src;
        payload_t         word;
    } entry_t;

    typedef struct packed {
        logic [1:0]       req;
        payload_t         word;
        logic [LEN_W-1:0] len;
        logic [SRC_W-1:0] src;
        logic             link;
        logic [1:0]       outcome;
    } item_t;

    typedef struct packed {
        status_t           status;
        payload_t          word;
        logic [LEN_W-1:0]  length;
        logic [SRC_W-1:0]  source;
        logic              long_path;
        logic [FILL_W-1:0] fill;
        logic [CTR_W-1:0]  ovf_cnt;
        logic [CTR_W-1:0]  inv_cnt;
        logic [CTR_W-1:0]  fail_cnt;
    } res_t;

    // Keep bytes below len in word w, zero the rest
    function automatic logic [WORD_W-1:0] word_mask(input logic [LEN_W-1:0] len,
                                                    input int w);
        logic [WORD_W-1:0] m;
        m = '0;
        for (int b = 0; b < WORD_W / 8; b++) begin
            m[b*8 +: 8] = (int'(len) > w * (WORD_W / 8) + b) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

endpackage

/* hdl/command_packet_queue_with_retry_unit.sv */
// Command packet queue with retry: top level.
//
// Input channel (in_valid / in_stall) carries one request transaction: push,
// take, completion or clear, with payload words, length, source id, link
// state and outcome. Output channel (out_valid / out_stall) returns exactly
// one result transaction per request: status, issued packet fields, fill
// level and the three drop counters.
// cfg_wr_en / cfg_wr_data write the long-path source id; write it only while
// the block is idle.
// A request is accepted in the idle state and executed in the execute state
// that follows; its result moves into the output register when it commits. The
// block takes no new request until the last result has been committed, and the
// queue memory is read at acceptance.
// Reset empties the queue and the hold slot, zeroes the counters and the
// long-path id; the queue memory itself is not cleared.
// While the receiver stalls, the result holds in the output register; the
// next request still executes and then waits, and in_stall stays high until
// its result can move into the output register.
module command_packet_queue_with_retry_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [63:0] data_word0,
    input  logic [63:0] data_word1,
    input  logic [63:0] data_word2,
    input  logic [63:0] data_word3,
    input  logic [5:0]  byte_count,
    input  logic [15:0] source_id,
    input  logic        link_up,
    input  logic [1:0]  outcome,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  status,
    output logic [63:0] out_word0,
    output logic [63:0] out_word1,
    output logic [63:0] out_word2,
    output logic [63:0] out_word3,
    output logic [5:0]  out_length,
    output logic [15:0] out_source,
    output logic        use_long_path,
    output logic [3:0]  fill_level,
    output logic [31:0] overflow_drops,
    output logic [31:0] invalid_drops,
    output logic [31:0] fail_drops
);
    import cpq_pkg::*;

    logic [15:0]      long_path_reg;
    item_t            item;
    res_t             res;
    res_t             out_res;
    logic             res_valid;
    logic             res_ready;
    logic             ram_rd_en;
    logic [PTR_W-1:0] ram_rd_addr;
    entry_t           ram_rd_data;
    logic             ram_wr_en;
    logic [PTR_W-1:0] ram_wr_addr;
    entry_t           ram_wr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_path_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            long_path_reg <= cfg_wr_data;
        end
    end

    always_comb
    begin
        item.req     = req_type;
        item.word[0] = data_word0;
        item.word[1] = data_word1;
        item.word[2] = data_word2;
        item.word[3] = data_word3;
        item.len     = byte_count;
        item.src     = source_id;
        item.link    = link_up;
        item.outcome = outcome;
    end

    cpq_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    cpq_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (in_valid),
        .item_stall   (in_stall),
        .item         (item),
        .long_path_id (long_path_reg),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .ram_rd_en    (ram_rd_en),
        .ram_rd_addr  (ram_rd_addr),
        .ram_rd_data  (ram_rd_data),
        .ram_wr_en    (ram_wr_en),
        .ram_wr_addr  (ram_wr_addr),
        .ram_wr_data  (ram_wr_data)
    );

    cpq_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign status         = out_res.status;
    assign out_word0      = out_res.word[0];
    assign out_word1      = out_res.word[1];
    assign out_word2      = out_res.word[2];
    assign out_word3      = out_res.word[3];
    assign out_length     = out_res.length;
    assign out_source     = out_res.source;
    assign use_long_path  = out_res.long_path;
    assign fill_level     = out_res.fill;
    assign overflow_drops = out_res.ovf_cnt;
    assign invalid_drops  = out_res.inv_cnt;
    assign fail_drops     = out_res.fail_cnt;

endmodule

/* hdl/cpq_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module cpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* hdl/cpq_ctrl.sv */
// Queue sequencer: pointers, hold slot, drop counters and result formation.
module cpq_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  cpq_pkg::item_t        item,
    input  logic [15:0]           long_path_id,
    output logic                  res_valid,
    input  logic                  res_ready,
    output cpq_pkg::res_t         res,
    output logic                  ram_rd_en,
    output logic [cpq_pkg::PTR_W-1:0] ram_rd_addr,
    input  cpq_pkg::entry_t       ram_rd_data,
    output logic                  ram_wr_en,
    output logic [cpq_pkg::PTR_W-1:0] ram_wr_addr,
    output cpq_pkg::entry_t       ram_wr_data
);
    import cpq_pkg::*;

    fsm_t             state_reg, state_next;
    item_t            item_reg;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [CNT_W-1:0] count_reg, count_next;
    entry_t           held_reg, held_next;
    logic             held_valid_reg, held_valid_next;
    logic [CTR_W-1:0] ovf_reg, ovf_next;
    logic [CTR_W-1:0] inv_reg, inv_next;
    logic [CTR_W-1:0] fail_reg, fail_next;

    logic   accept;
    logic   commit;
    logic   push_ok;
    entry_t iss;
    entry_t pushed;

    assign accept = item_valid && (state_reg == FSM_IDLE);

    // The queue head is read at acceptance, so its data is ready in the execute cycle
    assign ram_rd_en   = (state_reg == FSM_IDLE);
    assign ram_rd_addr = rp_reg;

    always_comb
    begin
        for (int w = 0; w < NUM_WORDS; w++) begin
            pushed.word[w] = item_reg.word[w] & word_mask(item_reg.len, w);
        end
        pushed.len = item_reg.len;
        pushed.src = item_reg.src;
    end

    assign iss = held_valid_reg ? held_reg : ram_rd_data;

    always_comb
    begin
        state_next      = state_reg;
        item_stall      = (state_reg != FSM_IDLE);
        res_valid       = (state_reg == FSM_EXEC);
        commit          = res_valid && res_ready;
        rp_next         = rp_reg;
        wp_next         = wp_reg;
        count_next      = count_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        ovf_next        = ovf_reg;
        inv_next        = inv_reg;
        fail_next       = fail_reg;
        push_ok         = 1'b0;
        res             = '0;
        res.status      = STAT_IGNORED;

        case (req_t'(item_reg.req))
            REQ_PUSH:
            begin
                if (item_reg.len == '0 || item_reg.len > LEN_W'(MAX_PACKET_BYTES))
                begin
                    inv_next   = inv_reg + CTR_W'(1);
                    res.status = STAT_REJECTED;
                end
                else
                begin
                    push_ok    = 1'b1;
                    res.status = STAT_PUSHED;
                    wp_next    = ptr_inc(wp_reg);
                    if (count_reg == CNT_W'(QUEUE_DEPTH))
                    begin
                        // drop oldest, count stays at full
                        rp_next    = ptr_inc(rp_reg);
                        ovf_next   = ovf_reg + CTR_W'(1);
                        res.status = STAT_EVICTED;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            REQ_TAKE:
            begin
                if (item_reg.link)
                begin
                    if (held_valid_reg || count_reg != '0)
                    begin
                        if (!held_valid_reg)
                        begin
                            held_next       = ram_rd_data;
                            held_valid_next = 1'b1;
                            rp_next         = ptr_inc(rp_reg);
                            count_next      = count_reg - CNT_W'(1);
                        end
                        res.status    = STAT_ISSUED;
                        res.word      = iss.word;
                        res.length    = iss.len;
                        res.source    = iss.src;
                        res.long_path = (iss.src == long_path_id);
                    end
                    else
                    begin
                        res.status = STAT_NOTHING;
                    end
                end
            end
            REQ_COMPLETE:
            begin
                if (held_valid_reg)
                begin
                    case (item_reg.outcome)
                        OUTC_SENT:
                        begin
                            held_valid_next = 1'b0;
                            res.status      = STAT_SENT;
                        end
                        OUTC_NOT_YET:
                        begin
                            res.status = STAT_HELD;
                        end
                        OUTC_FAILED:
                        begin
                            held_valid_next = 1'b0;
                            fail_next       = fail_reg + CTR_W'(1);
                            res.status      = STAT_DROPPED;
                        end
                        default:
                        begin
                            res.status = STAT_IGNORED;
                        end
                    endcase
                end
            end
            REQ_CLEAR:
            begin
                held_valid_next = 1'b0;
                res.status      = STAT_CLEARED;
            end
            default:
            begin
                res.status = STAT_IGNORED;
            end
        endcase

        res.fill     = FILL_W'(count_next);
        res.ovf_cnt  = ovf_next;
        res.inv_cnt  = inv_next;
        res.fail_cnt = fail_next;

        case (state_reg)
            FSM_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC:
            begin
                if (res_ready)
                begin
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    assign ram_wr_en   = commit && push_ok;
    assign ram_wr_addr = wp_reg;
    assign ram_wr_data = pushed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_reg         <= '0;
            wp_reg         <= '0;
            count_reg      <= '0;
            held_valid_reg <= 1'b0;
            ovf_reg        <= '0;
            inv_reg        <= '0;
            fail_reg       <= '0;
        end
        else if (commit)
        begin
            rp_reg         <= rp_next;
            wp_reg         <= wp_next;
            count_reg      <= count_next;
            held_valid_reg <= held_valid_next;
            ovf_reg        <= ovf_next;
            inv_reg        <= inv_next;
            fail_reg       <= fail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
        if (commit)
        begin
            held_reg <= held_next;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == CNT_W'(QUEUE_DEPTH)) |-> (rp_reg == wp_reg))
        else $error("pointers disagree with empty or full count");

    a_issue_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && res.status == STAT_ISSUED) |=> held_valid_reg)
        else $error("issued packet not kept in hold slot");

    a_reject_count: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && res.status == STAT_REJECTED) |=> (inv_reg == $past(inv_reg) + CTR_W'(1)))
        else $error("rejected push not counted");

endmodule

/* hdl/cpq_obuf.sv */
// One-entry output register between the sequencer and the result channel.
module cpq_obuf (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          res_valid,
    output logic          res_ready,
    input  cpq_pkg::res_t res,
    output logic          out_valid,
    input  logic          out_stall,
    output cpq_pkg::res_t out_res
);
    import cpq_pkg::*;

    logic valid_reg, valid_next;
    res_t data_reg;

    assign res_ready  = !valid_reg || !out_stall;
    assign valid_next = (res_valid && res_ready) || (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            data_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = data_reg;

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the command packet queue with retry unit.
`timescale 1ns / 100ps

module tb_top;
    import cpq_pkg::*;

    localparam int NUM_PHASES     = 6;
    localparam int PHASE_REQUESTS = 340;
    localparam int SETTLE_CYCLES  = 8;
    // Longest quiet stretch of a correct run: the longest sender gap plus a rare
    // long stall streak; taken several times over.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_LIMIT   = 10;

    // Completion outcome code with no meaning to the block
    localparam logic [1:0] OUTC_UNDEFINED = 2'd3;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_e;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        in_valid      = 1'b0;
    logic        in_stall;
    logic [1:0]  req_type      = REQ_PUSH;
    logic [63:0] data_word0    = '0;
    logic [63:0] data_word1    = '0;
    logic [63:0] data_word2    = '0;
    logic [63:0] data_word3    = '0;
    logic [5:0]  byte_count    = '0;
    logic [15:0] source_id     = '0;
    logic        link_up       = 1'b0;
    logic [1:0]  outcome       = OUTC_SENT;
    logic        cfg_wr_en     = 1'b0;
    logic [15:0] cfg_wr_data   = '0;
    logic        out_valid;
    logic        out_stall     = 1'b0;
    logic [3:0]  status;
    logic [63:0] out_word0;
    logic [63:0] out_word1;
    logic [63:0] out_word2;
    logic [63:0] out_word3;
    logic [5:0]  out_length;
    logic [15:0] out_source;
    logic        use_long_path;
    logic [3:0]  fill_level;
    logic [31:0] overflow_drops;
    logic [31:0] invalid_drops;
    logic [31:0] fail_drops;

    always #5 clk = ~clk;

    command_packet_queue_with_retry_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .data_word0     (data_word0),
        .data_word1     (data_word1),
        .data_word2     (data_word2),
        .data_word3     (data_word3),
        .byte_count     (byte_count),
        .source_id      (source_id),
        .link_up        (link_up),
        .outcome        (outcome),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .out_word0      (out_word0),
        .out_word1      (out_word1),
        .out_word2      (out_word2),
        .out_word3      (out_word3),
        .out_length     (out_length),
        .out_source     (out_source),
        .use_long_path  (use_long_path),
        .fill_level     (fill_level),
        .overflow_drops (overflow_drops),
        .invalid_drops  (invalid_drops),
        .fail_drops     (fail_drops)
    );

    // Mirror of the queue, hold slot, counters and long-path register
    entry_t            model_queue [QUEUE_DEPTH];
    entry_t            model_held;
    logic              model_held_valid = 1'b0;
    logic [PTR_W-1:0]  model_rd         = '0;
    logic [PTR_W-1:0]  model_wr         = '0;
    int                model_count      = 0;
    logic [CTR_W-1:0]  model_ovf        = '0;
    logic [CTR_W-1:0]  model_inv        = '0;
    logic [CTR_W-1:0]  model_fail       = '0;
    logic [SRC_W-1:0]  model_long_id    = '0;

    item_t  request_backlog [$];
    res_t   due_responses   [$];
    item_t  current_request;
    res_t   monitor_want;
    int     mismatch_count  = 0;
    int     idle_cycles     = 0;

    int     gap_left        = 0;
    int     burst_left      = 1;
    logic   drain_hold      = 1'b0;

    stall_mode_e stall_mode = STALL_NONE;
    int     stall_mode_left = 0;
    int     stall_tick      = 0;

    function automatic res_t service_request(input item_t it);
        res_t                           r;
        logic [NUM_WORDS*WORD_W-1:0]    keep;
        logic                           issue;
        r        = '0;
        r.status = STAT_IGNORED;
        issue    = 1'b0;
        case (it.req)
            REQ_PUSH: begin
                if (it.len == 0 || it.len > MAX_PACKET_BYTES) begin
                    model_inv++;
                    r.status = STAT_REJECTED;
                end else begin
                    r.status = STAT_PUSHED;
                    if (model_count >= QUEUE_DEPTH) begin
                        // evict the oldest packet to make room
                        model_rd = PTR_W'((model_rd + 1) % QUEUE_DEPTH);
                        model_count--;
                        model_ovf++;
                        r.status = STAT_EVICTED;
                    end
                    keep = '1;
                    keep = keep >> (NUM_WORDS * WORD_W - 8 * int'(it.len));
                    model_queue[model_wr].len  = it.len;
                    model_queue[model_wr].src  = it.src;
                    model_queue[model_wr].word = it.word & keep;
                    model_wr = PTR_W'((model_wr + 1) % QUEUE_DEPTH);
                    model_count++;
                end
            end
            REQ_TAKE: begin
                if (!it.link) begin
                    r.status = STAT_IGNORED;
                end else if (model_held_valid) begin
                    issue = 1'b1;
                end else if (model_count > 0) begin
                    model_held       = model_queue[model_rd];
                    model_held_valid = 1'b1;
                    model_rd         = PTR_W'((model_rd + 1) % QUEUE_DEPTH);
                    model_count--;
                    issue = 1'b1;
                end else begin
                    r.status = STAT_NOTHING;
                end
                if (issue) begin
                    r.status    = STAT_ISSUED;
                    r.word      = model_held.word;
                    r.length    = model_held.len;
                    r.source    = model_held.src;
                    r.long_path = (model_held.src == model_long_id);
                end
            end
            REQ_COMPLETE: begin
                if (model_held_valid) begin
                    case (it.outcome)
                        OUTC_SENT: begin
                            model_held_valid = 1'b0;
                            r.status = STAT_SENT;
                        end
                        OUTC_NOT_YET: r.status = STAT_HELD;
                        OUTC_FAILED: begin
                            model_held_valid = 1'b0;
                            model_fail++;
                            r.status = STAT_DROPPED;
                        end
                        default: r.status = STAT_IGNORED;
                    endcase
                end
            end
            default: begin
                model_held_valid = 1'b0;
                r.status = STAT_CLEARED;
            end
        endcase
        r.fill     = FILL_W'(model_count);
        r.ovf_cnt  = model_ovf;
        r.inv_cnt  = model_inv;
        r.fail_cnt = model_fail;
        return r;
    endfunction

    function automatic payload_t random_payload();
        payload_t p;
        for (int w = 0; w < NUM_WORDS; w++)
            p[w] = {$urandom, $urandom};
        return p;
    endfunction

    function automatic item_t make_request(input req_t kind, input int len,
                                           input logic [15:0] src, input logic link,
                                           input logic [1:0] oc, input payload_t data);
        item_t it;
        it.req     = kind;
        it.word    = data;
        it.len     = LEN_W'(len);
        it.src     = src;
        it.link    = link;
        it.outcome = oc;
        return it;
    endfunction

    function automatic item_t random_request(input int push_pct, input logic [15:0] hot_src);
        item_t it;
        int    pick;
        it.req     = REQ_CLEAR;
        it.word    = random_payload();
        it.len     = LEN_W'($urandom_range(0, 63));
        it.src     = SRC_W'($urandom);
        it.link    = 1'($urandom);
        it.outcome = 2'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < push_pct) begin
            it.req = REQ_PUSH;
            case ($urandom_range(0, 19))
                0:       it.len = '0;
                1:       it.len = LEN_W'($urandom_range(MAX_PACKET_BYTES + 1, 63));
                2:       it.len = LEN_W'(1);
                3:       it.len = LEN_W'(MAX_PACKET_BYTES);
                default: it.len = LEN_W'($urandom_range(1, MAX_PACKET_BYTES));
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2, 3: it.src = hot_src;
                4:          it.src = '0;
                5:          it.src = '1;
                default:    ;
            endcase
            case ($urandom_range(0, 9))
                0:       it.word = '1;
                1:       it.word = '0;
                default: ;
            endcase
        end else if (pick < push_pct + (100 - push_pct) * 45 / 100) begin
            it.req  = REQ_TAKE;
            it.link = ($urandom_range(0, 9) != 0);
        end else if (pick < push_pct + (100 - push_pct) * 85 / 100) begin
            it.req     = REQ_COMPLETE;
            it.outcome = ($urandom_range(0, 19) == 0) ? OUTC_UNDEFINED
                                                      : 2'($urandom_range(0, 2));
        end
        return it;
    endfunction

    task automatic check_field(input string field, input logic [63:0] want_v,
                               input logic [63:0] got_v);
        if (want_v !== got_v) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("mismatch on %s: expected %h, got %h", field, want_v, got_v);
        end
    endtask

    // Driver: feed the backlog in bursts, hold the payload while stalled
    always @(posedge clk) begin
        logic go;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall)
                due_responses.push_back(service_request(current_request));
            if (!(in_valid && in_stall)) begin
                go = 1'b0;
                if (drain_hold)
                    drain_hold = (due_responses.size() != 0);
                else if (gap_left > 0)
                    gap_left--;
                else if (request_backlog.size() > 0)
                    go = 1'b1;
                if (go) begin
                    current_request = request_backlog.pop_front();
                    req_type   <= current_request.req;
                    data_word0 <= current_request.word[0];
                    data_word1 <= current_request.word[1];
                    data_word2 <= current_request.word[2];
                    data_word3 <= current_request.word[3];
                    byte_count <= current_request.len;
                    source_id  <= current_request.src;
                    link_up    <= current_request.link;
                    outcome    <= current_request.outcome;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                                 : $urandom_range(1, 12);
                        case ($urandom_range(0, 3))
                            0:       gap_left = 0;
                            1, 2:    gap_left = $urandom_range(1, 3);
                            default: gap_left = $urandom_range(4, 12);
                        endcase
                        // now and then wait for every response before going on
                        if ($urandom_range(0, 9) == 0)
                            drain_hold = 1'b1;
                    end
                end
                in_valid <= go;
            end
        end
    end

    // Monitor: check each response, and stall on a pattern of its own
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (due_responses.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("unexpected response with status %0d", status);
                end else begin
                    monitor_want = due_responses.pop_front();
                    check_field("status", 64'(monitor_want.status), 64'(status));
                    check_field("out_word0", monitor_want.word[0], out_word0);
                    check_field("out_word1", monitor_want.word[1], out_word1);
                    check_field("out_word2", monitor_want.word[2], out_word2);
                    check_field("out_word3", monitor_want.word[3], out_word3);
                    check_field("out_length", 64'(monitor_want.length), 64'(out_length));
                    check_field("out_source", 64'(monitor_want.source), 64'(out_source));
                    check_field("use_long_path", 64'(monitor_want.long_path),
                                64'(use_long_path));
                    check_field("fill_level", 64'(monitor_want.fill), 64'(fill_level));
                    check_field("overflow_drops", 64'(monitor_want.ovf_cnt),
                                64'(overflow_drops));
                    check_field("invalid_drops", 64'(monitor_want.inv_cnt),
                                64'(invalid_drops));
                    check_field("fail_drops", 64'(monitor_want.fail_cnt), 64'(fail_drops));
                end
            end
            if (stall_mode_left <= 0) begin
                stall_mode      = stall_mode_e'($urandom_range(0, 3));
                stall_mode_left = $urandom_range(50, 300);
            end
            stall_mode_left--;
            stall_tick++;
            case (stall_mode)
                STALL_NONE:     out_stall <= 1'b0;
                STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY:    out_stall <= ($urandom_range(0, 9) < 7);
                default:        out_stall <= ((stall_tick % 5) < 3);
            endcase
        end
    end

    // Watchdog: end the run if no transaction moves for too long
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        int unsigned      fill_lens [9];
        logic [15:0]      long_id;
        int               push_pct;
        fill_lens = '{1, 32, 8, 9, 31, 17, 24, 25, 16};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // wait until the block is idle before touching the register
            while (request_backlog.size() != 0 || in_valid || due_responses.size() != 0)
                @(negedge clk);
            case (ph)
                0, 3:    long_id = 16'hFFFF;
                1:       long_id = 16'h0000;
                5:       long_id = 16'h0001;
                default: long_id = 16'($urandom);
            endcase
            @(posedge clk);
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= long_id;
            model_long_id = long_id;
            @(posedge clk);
            cfg_wr_en <= 1'b0;
            if (ph == 0) begin
                request_backlog.push_back(make_request(REQ_TAKE, 0, 16'h0000, 1'b1,
                                                       OUTC_SENT, '0));
                request_backlog.push_back(make_request(REQ_TAKE, 63, 16'hFFFF, 1'b0,
                                                       OUTC_UNDEFINED, '1));
                request_backlog.push_back(make_request(REQ_COMPLETE, 0, 16'h0000, 1'b1,
                                                       OUTC_SENT, '0));
                request_backlog.push_back(make_request(REQ_CLEAR, 0, 16'h0000, 1'b0,
                                                       OUTC_SENT, '0));
                request_backlog.push_back(make_request(REQ_PUSH, 0, 16'h1234, 1'b1,
                                                       OUTC_SENT, '1));
                request_backlog.push_back(make_request(REQ_PUSH, 33, 16'h1234, 1'b1,
                                                       OUTC_SENT, '1));
                request_backlog.push_back(make_request(REQ_PUSH, 63, 16'h1234, 1'b1,
                                                       OUTC_SENT, '1));
                // fill the queue, then push once more to evict the oldest
                foreach (fill_lens[i])
                    request_backlog.push_back(make_request(REQ_PUSH, fill_lens[i],
                        (i % 2 == 0) ? 16'hFFFF : 16'($urandom), 1'b0, OUTC_SENT,
                        (i % 2 == 0) ? payload_t'('1) : random_payload()));
                request_backlog.push_back(make_request(REQ_TAKE, 0, 0, 1'b1, OUTC_SENT, '0));
                request_backlog.push_back(make_request(REQ_TAKE, 0, 0, 1'b1, OUTC_SENT, '0));
                request_backlog.push_back(make_request(REQ_COMPLETE, 0, 0, 1'b1,
                                                       OUTC_NOT_YET, '0));
                request_backlog.push_back(make_request(REQ_COMPLETE, 0, 0, 1'b1,
                                                       OUTC_UNDEFINED, '0));
                request_backlog.push_back(make_request(REQ_COMPLETE, 0, 0, 1'b1,
                                                       OUTC_FAILED, '0));
                request_backlog.push_back(make_request(REQ_TAKE, 0, 0, 1'b1, OUTC_SENT, '0));
                request_backlog.push_back(make_request(REQ_COMPLETE, 0, 0, 1'b1,
                                                       OUTC_SENT, '0));
                request_backlog.push_back(make_request(REQ_TAKE, 0, 0, 1'b1, OUTC_SENT, '0));
                request_backlog.push_back(make_request(REQ_CLEAR, 0, 0, 1'b1, OUTC_SENT, '0));
            end else begin
                push_pct = 25 + 8 * ph;
                repeat (PHASE_REQUESTS)
                    request_backlog.push_back(random_request(push_pct, long_id));
            end
        end
        while (request_backlog.size() != 0 || in_valid || due_responses.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (due_responses.size() != 0) begin
            mismatch_count += due_responses.size();
            $display("%0d responses never arrived", due_responses.size());
        end
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
